// ----- src/dq_pkg.sv -----
// Shared constants, request and status codes, and types for the double-ended queue.
// Used by dq_ctrl and double_ended_queue; depends on nothing.
`default_nettype none

package dq_pkg;

   localparam int CAPACITY   = 1024;
   localparam int DATA_WIDTH = 32;

   localparam int PTR_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);

   localparam int TYPE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ       = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [PTR_W-1:0]      addr;
      logic [DATA_WIDTH-1:0] wr_data;
   } mem_cmd_type;

   typedef struct packed {
      logic                read;
      logic [CNT_W-1:0]    count;
      logic [STATUS_W-1:0] status;
   } rsp_info_type;

   // Position off steps after pos, wrapping at the capacity. off never exceeds the capacity.
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] pos,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(pos) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(CAPACITY)) begin
         sum = sum - (CNT_W + 1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/double_ended_queue.sv -----
// Top level of the double-ended queue: request handshake, ring memory and result register.
// Depends on dq_pkg, dq_ring_ram and dq_ctrl.
//
// Usage:
//   Requests arrive on the req_ channel (valid/ready). Each beat pushes at the front,
//   pushes at the back, pops from the front, pops from the back or reads the element
//   at req_index from the front. Every request gives exactly one rsp_ beat with the
//   element popped or read (zero otherwise), the count after the request and a status:
//   ok, empty on pop, full on push, or index out of range. A failed request leaves the
//   queue unchanged; an unknown request type is answered with status ok and no change.
//   The result passes through the holding stage and then the result register before
//   it is offered as an rsp_ beat.
//   Throughput: one request per cycle while rsp_ready is high. Pointer and count update
//   at acceptance, and each request makes at most one access to the single ring memory,
//   whose registered read data waits beside the holding stage.
//   Reset clears the head pointer and the count; the ring contents are not cleared and
//   need no clearing pass, as only entries inside the count are ever read.
//   When the receiver stalls, the result register holds, the holding stage fills, and
//   req_ready drops until the result is taken; no beat is lost.
`default_nettype none

module double_ended_queue (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [dq_pkg::TYPE_W-1:0]       req_type,
   input  wire logic [dq_pkg::VALUE_W-1:0]      req_push_value,
   input  wire logic [dq_pkg::INDEX_W-1:0]      req_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [dq_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic      [dq_pkg::COUNT_W-1:0]      rsp_count,
   output logic      [dq_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int VW = dq_pkg::VALUE_W;
   localparam int KW = dq_pkg::COUNT_W;

   dq_pkg::mem_cmd_type  mem_cmd;
   dq_pkg::rsp_info_type rsp_info;

   logic [dq_pkg::DATA_WIDTH-1:0] rd_data;

   logic                 req_fire;
   logic                 s1_advance;
   logic                 s1_valid_ff;
   dq_pkg::rsp_info_type s1_info_ff;

   logic                        rsp_valid_ff;
   logic [VW-1:0]               rsp_read_value_ff;
   logic [KW-1:0]               rsp_count_ff;
   logic [dq_pkg::STATUS_W-1:0] rsp_status_ff;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_fire   = req_valid && req_ready;

   dq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .req_index      (req_index),
      .mem_cmd        (mem_cmd),
      .rsp_info       (rsp_info)
   );

   // The read data stays put while the holding stage waits, as no new read is issued then.
   dq_ring_ram #(
      .WIDTH (dq_pkg::DATA_WIDTH),
      .DEPTH (dq_pkg::CAPACITY)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (mem_cmd.addr),
      .wr_data (mem_cmd.wr_data),
      .rd_en   (mem_cmd.rd_en),
      .rd_addr (mem_cmd.addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         s1_info_ff <= rsp_info;
      end
      if (s1_advance) begin
         rsp_read_value_ff <= s1_info_ff.read ? VW'(rd_data) : '0;
         rsp_count_ff      <= KW'(s1_info_ff.count);
         rsp_status_ff     <= s1_info_ff.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   a_fail_no_read: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_info_ff.status != dq_pkg::ST_OK |-> !s1_info_ff.read)
      else $error("failed request marked as returning data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_info_ff.status == dq_pkg::ST_FULL
         |-> 32'(s1_info_ff.count) == dq_pkg::CAPACITY)
      else $error("full status with a count below capacity");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_info_ff))
      else $error("holding stage overwritten while waiting");

endmodule

`default_nettype wire

// ----- src/dq_ring_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
`default_nettype none

module dq_ring_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/dq_ctrl.sv -----
// Head pointer and element count of the ring; decodes each request into at most one memory access.
// Depends on dq_pkg.
`default_nettype none

module dq_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_fire,
   input  wire logic [dq_pkg::TYPE_W-1:0]      req_type,
   input  wire logic [dq_pkg::VALUE_W-1:0]     req_push_value,
   input  wire logic [dq_pkg::INDEX_W-1:0]     req_index,
   output dq_pkg::mem_cmd_type                 mem_cmd,
   output dq_pkg::rsp_info_type                rsp_info
);

   localparam int PW = dq_pkg::PTR_W;
   localparam int CW = dq_pkg::CNT_W;
   localparam int DW = dq_pkg::DATA_WIDTH;
   localparam int XW = dq_pkg::CMP_W;

   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   logic          full, empty;
   logic [PW-1:0] head_prev;

   assign full      = (count_ff == CW'(dq_pkg::CAPACITY));
   assign empty     = (count_ff == '0);
   assign head_prev = (head_ff == '0) ? PW'(dq_pkg::CAPACITY - 1) : head_ff - 1'b1;

   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      mem_cmd.wr_en    = 1'b0;
      mem_cmd.rd_en    = 1'b0;
      mem_cmd.addr     = head_ff;
      mem_cmd.wr_data  = DW'(req_push_value);
      rsp_info.read    = 1'b0;
      rsp_info.status  = dq_pkg::ST_OK;

      unique case (req_type)
         dq_pkg::REQ_PUSH_FRONT: begin
            if (full) begin
               rsp_info.status = dq_pkg::ST_FULL;
            end else begin
               head_in       = head_prev;
               count_in      = count_ff + 1'b1;
               mem_cmd.wr_en = 1'b1;
               mem_cmd.addr  = head_prev;
            end
         end
         dq_pkg::REQ_PUSH_BACK: begin
            if (full) begin
               rsp_info.status = dq_pkg::ST_FULL;
            end else begin
               count_in      = count_ff + 1'b1;
               mem_cmd.wr_en = 1'b1;
               mem_cmd.addr  = dq_pkg::ring_add(head_ff, count_ff);
            end
         end
         dq_pkg::REQ_POP_FRONT: begin
            if (empty) begin
               rsp_info.status = dq_pkg::ST_EMPTY;
            end else begin
               head_in       = dq_pkg::ring_add(head_ff, CW'(1));
               count_in      = count_ff - 1'b1;
               mem_cmd.rd_en = 1'b1;
               rsp_info.read = 1'b1;
            end
         end
         dq_pkg::REQ_POP_BACK: begin
            if (empty) begin
               rsp_info.status = dq_pkg::ST_EMPTY;
            end else begin
               count_in      = count_ff - 1'b1;
               mem_cmd.rd_en = 1'b1;
               mem_cmd.addr  = dq_pkg::ring_add(head_ff, count_ff - 1'b1);
               rsp_info.read = 1'b1;
            end
         end
         dq_pkg::REQ_READ: begin
            if (XW'(req_index) >= XW'(count_ff)) begin
               rsp_info.status = dq_pkg::ST_RANGE;
            end else begin
               // The index is below the count here, so it fits the count's width.
               mem_cmd.rd_en = 1'b1;
               mem_cmd.addr  = dq_pkg::ring_add(head_ff, CW'(req_index));
               rsp_info.read = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (!req_fire) begin
         head_in       = head_ff;
         count_in      = count_ff;
         mem_cmd.wr_en = 1'b0;
         mem_cmd.rd_en = 1'b0;
      end
      rsp_info.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(dq_pkg::CAPACITY))
      else $error("element count above capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < dq_pkg::CAPACITY)
      else $error("head pointer outside the ring");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("read and write issued for one request");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("successful push did not grow the count");

endmodule

`default_nettype wire
